>>> rtl/core/cfct_pkg.sv
// Shared constants, status codes and compare-result type for the chunk coverage tracker.
`timescale 1ns / 1ps
`default_nettype none

package cfct_pkg;

  localparam int MAX_RANGES_DEF = 16;
  localparam int SIZE_BITS_DEF  = 24;
  localparam int CHUNK_RESET    = 1024;

  localparam int STATUS_W    = 2;
  localparam int OUT_TOTAL_W = 5;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic touch;
    logic b_lt_s;
    logic a_lt_us;
    logic b_gt_ue;
  } cmp_t;

endpackage

`default_nettype wire

>>> rtl/core/cfct_cmp.sv
// Shared interval compare unit: one stored interval against the fragment and running union.
`timescale 1ns / 1ps
`default_nettype none

module cfct_cmp #(
  parameter int SIZE_BITS = cfct_pkg::SIZE_BITS_DEF
) (
  input  wire logic [SIZE_BITS-1:0] a,
  input  wire logic [SIZE_BITS-1:0] b,
  input  wire logic [SIZE_BITS-1:0] s,
  input  wire logic [SIZE_BITS-1:0] e,
  input  wire logic [SIZE_BITS-1:0] us,
  input  wire logic [SIZE_BITS-1:0] ue,
  output cfct_pkg::cmp_t            res
);

  // Intervals that overlap or merely touch the fragment are merged with it.
  assign res.touch   = (a <= e) && (b >= s);
  assign res.b_lt_s  = (b < s);
  assign res.a_lt_us = (a < us);
  assign res.b_gt_ue = (b > ue);

endmodule

`default_nettype wire

>>> rtl/core/cfct_mem.sv
// Simple dual-port interval memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cfct_mem #(
  parameter int ADDR_BITS = 5,
  parameter int WIDTH     = 48
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/chunk_fragment_coverage_tracker.sv
// A rejected or empty fragment goes straight to the result; a merge takes one scan pass and one
// copy pass over the interval memory, one entry per cycle through its single read port, and a
// full-list rejection takes the scan pass only.
// One fragment is in work at a time; the next beat is taken once the result sits in the output
// register. Synchronous reset empties the list and loads 1024.
`timescale 1ns / 1ps
`default_nettype none

module chunk_fragment_coverage_tracker #(
  parameter int MAX_RANGES = cfct_pkg::MAX_RANGES_DEF,
  parameter int SIZE_BITS  = cfct_pkg::SIZE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [SIZE_BITS-1:0]             cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             restart,
  input  wire logic [SIZE_BITS-1:0]             frag_offset,
  input  wire logic [SIZE_BITS-1:0]             frag_length,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  complete,
  output logic [cfct_pkg::STATUS_W-1:0]         status,
  output logic [cfct_pkg::OUT_TOTAL_W-1:0]      interval_total
);

  localparam int CW    = $clog2(MAX_RANGES + 1);
  localparam int AW    = $clog2(MAX_RANGES);
  localparam int MAW   = AW + 1;
  localparam int OUT_W = cfct_pkg::OUT_TOTAL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state;
  logic [SIZE_BITS-1:0]        chunk_bytes;
  logic [CW-1:0]               count;
  logic [CW-1:0]               new_count;
  logic [CW-1:0]               idx;
  logic [CW-1:0]               touched;
  logic [CW-1:0]               lead;
  logic                        bank;
  logic                        done_flag;
  logic                        rd_pend;
  logic                        wp_valid;
  logic                        wp_merge;
  logic [AW-1:0]               wp_dst;
  logic [SIZE_BITS-1:0]        s;
  logic [SIZE_BITS-1:0]        e;
  logic [SIZE_BITS-1:0]        us;
  logic [SIZE_BITS-1:0]        ue;
  logic [SIZE_BITS-1:0]        head_start;
  logic [SIZE_BITS-1:0]        head_end;
  logic [cfct_pkg::STATUS_W-1:0] stat;

  logic                        in_accept;
  logic [SIZE_BITS:0]          frag_end;
  logic                        range_bad;
  logic                        scan_issue;
  logic                        scan_end;
  logic                        copy_issue;
  logic                        copy_end;
  logic                        copy_merge;
  logic [CW-1:0]               copy_src;
  logic                        out_free;
  logic                        done_new;
  logic                        list_full;
  logic [MAW-1:0]              mem_raddr;
  logic [MAW-1:0]              mem_waddr;
  logic [2*SIZE_BITS-1:0]      mem_wdata;
  logic [2*SIZE_BITS-1:0]      mem_rdata;
  logic [SIZE_BITS-1:0]        rd_a;
  logic [SIZE_BITS-1:0]        rd_b;
  logic [CW+OUT_W-1:0]         count_wide;
  cfct_pkg::cmp_t              cmp;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign frag_end  = {1'b0, frag_offset} + {1'b0, frag_length};
  assign range_bad = (frag_end > {1'b0, chunk_bytes});

  assign scan_issue = (state == S_SCAN) && (idx < count);
  assign scan_end   = (state == S_SCAN) && !scan_issue && !rd_pend;
  assign copy_issue = (state == S_COPY) && (idx < new_count);
  assign copy_end   = (state == S_COPY) && !copy_issue && !wp_valid;
  assign copy_merge = (idx == lead);
  // Entries after the merged slot come from past the run of touched entries.
  assign copy_src   = (idx < lead) ? idx : (idx + touched - CW'(1));
  assign list_full  = (touched == '0) && (count == CW'(MAX_RANGES));

  assign mem_raddr = (state == S_SCAN) ? {bank, idx[AW-1:0]} : {bank, copy_src[AW-1:0]};
  assign mem_waddr = {~bank, wp_dst};
  assign mem_wdata = wp_merge ? {us, ue} : mem_rdata;
  assign rd_a      = mem_rdata[2*SIZE_BITS-1:SIZE_BITS];
  assign rd_b      = mem_rdata[SIZE_BITS-1:0];

  assign out_free = !out_valid || !out_stall;
  assign done_new = done_flag || ((count != '0) && (head_start == '0) &&
                    (head_end == chunk_bytes) && (chunk_bytes != '0));
  assign count_wide = {{OUT_W{1'b0}}, count};

  cfct_cmp #(
    .SIZE_BITS(SIZE_BITS)
  ) u_cmp (
    .a   (rd_a),
    .b   (rd_b),
    .s   (s),
    .e   (e),
    .us  (us),
    .ue  (ue),
    .res (cmp)
  );

  cfct_mem #(
    .ADDR_BITS(MAW),
    .WIDTH    (2 * SIZE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (wp_valid),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= SIZE_BITS'(cfct_pkg::CHUNK_RESET);
    end else if (cfg_wr_en) begin
      chunk_bytes <= cfg_wr_data;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done_flag <= 1'b0;
      bank      <= 1'b0;
      rd_pend   <= 1'b0;
      wp_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend  <= scan_issue;
      wp_valid <= copy_issue;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (restart) begin
              count     <= '0;
              done_flag <= 1'b0;
            end
            if (range_bad || (frag_length == '0)) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= list_full ? S_FIN : S_COPY;
          end
        end
        S_COPY: begin
          if (copy_end) begin
            bank  <= ~bank;
            count <= new_count;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            done_flag <= done_new;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (wp_valid && (wp_dst == '0)) begin
      head_start <= mem_wdata[2*SIZE_BITS-1:SIZE_BITS];
      head_end   <= mem_wdata[SIZE_BITS-1:0];
    end
    wp_merge <= copy_merge;
    wp_dst   <= idx[AW-1:0];
    case (state)
      S_IDLE: begin
        s       <= frag_offset;
        e       <= frag_end[SIZE_BITS-1:0];
        us      <= frag_offset;
        ue      <= frag_end[SIZE_BITS-1:0];
        touched <= '0;
        lead    <= '0;
        idx     <= '0;
        stat    <= range_bad ? cfct_pkg::STAT_RANGE : cfct_pkg::STAT_OK;
      end
      S_SCAN: begin
        if (scan_issue) begin
          idx <= idx + CW'(1);
        end
        if (rd_pend) begin
          if (cmp.touch) begin
            touched <= touched + CW'(1);
            if (cmp.a_lt_us) begin
              us <= rd_a;
            end
            if (cmp.b_gt_ue) begin
              ue <= rd_b;
            end
          end
          if (cmp.b_lt_s) begin
            lead <= lead + CW'(1);
          end
        end
        if (scan_end) begin
          idx       <= '0;
          new_count <= count + CW'(1) - touched;
          if (list_full) begin
            stat <= cfct_pkg::STAT_FULL;
          end
        end
      end
      S_COPY: begin
        if (copy_issue) begin
          idx <= idx + CW'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          complete       <= done_new;
          status         <= stat;
          interval_total <= count_wide[OUT_W-1:0];
        end
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/cfct_checker.sv
// Port-level checker for the chunk coverage tracker and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cfct_checker #(
  parameter int MAX_RANGES = cfct_pkg::MAX_RANGES_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             complete,
  input wire logic [cfct_pkg::STATUS_W-1:0]    status,
  input wire logic [cfct_pkg::OUT_TOTAL_W-1:0] interval_total
);

  // A held result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(complete) && $stable(status) &&
    $stable(interval_total))
    else $error("output beat changed while stalled");

  // Each accepted fragment keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a fragment was accepted");

  // A full-list rejection only happens with every interval slot in use.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cfct_pkg::STAT_FULL) |->
    (interval_total == cfct_pkg::OUT_TOTAL_W'(MAX_RANGES)))
    else $error("list-full status with free interval slots");

  // A complete chunk always holds at least one interval.
  a_complete_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && complete |-> (interval_total != '0) || (MAX_RANGES >= 32))
    else $error("complete reported with an empty interval list");

endmodule

bind chunk_fragment_coverage_tracker cfct_checker #(
  .MAX_RANGES(MAX_RANGES)
) u_cfct_checker (.*);

`default_nettype wire

>>> sim/chunk_fragment_coverage_tracker_test.sv
// Self-checking testbench for the chunk fragment coverage tracker.
`timescale 1ns / 1ps

module chunk_fragment_coverage_tracker_test;
  import cfct_pkg::*;

  localparam int SPANS = MAX_RANGES_DEF;
  localparam int SW = SIZE_BITS_DEF;
  localparam int DRAIN_CYCLES = 2 * SPANS + 8;
  localparam int STALL_LIMIT = 3000;
  localparam int PARK_CYCLES = 300;
  localparam int PHASE_ITEMS = 220;
  localparam logic [SW-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic restart;
    logic [SW-1:0] offset;
    logic [SW-1:0] length;
  } frag_t;

  typedef struct packed {
    logic complete;
    logic [STATUS_W-1:0] status;
    logic [OUT_TOTAL_W-1:0] total;
  } coverage_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [SW-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic restart = 1'b0;
  logic [SW-1:0] frag_offset = '0;
  logic [SW-1:0] frag_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic complete;
  logic [STATUS_W-1:0] status;
  logic [OUT_TOTAL_W-1:0] interval_total;

  chunk_fragment_coverage_tracker dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart(restart),
    .frag_offset(frag_offset),
    .frag_length(frag_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .complete(complete),
    .status(status),
    .interval_total(interval_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted tracker state: the sorted interval list, its count, the sticky flag.
  logic [SW-1:0] chunk_size;
  logic [SW-1:0] span_base [SPANS];
  logic [SW:0] span_len [SPANS];
  int span_cnt;
  logic chunk_done;

  frag_t frag_backlog[$];
  coverage_t coverage_due[$];
  frag_t frag_live;

  int frags_queued, frags_sent, results_seen, fail_count;
  int full_drops, range_drops, completions, sizes_used;
  int send_gap, send_calm, recv_wait, recv_calm, park_left, quiet_cycles;
  bit send_quiet, recv_quiet;

  // Joins [lo, hi) with every stored interval it overlaps or touches.
  function automatic logic [STATUS_W-1:0] merge_span(logic [SW:0] lo, logic [SW:0] hi);
    logic [SW:0] new_base [SPANS];
    logic [SW:0] new_len [SPANS];
    logic [SW:0] u_lo, u_hi, a, b;
    int hits, n;
    bit placed;
    u_lo = lo;
    u_hi = hi;
    hits = 0;
    n = 0;
    placed = 1'b0;
    for (int i = 0; i < span_cnt; i++) begin
      a = {1'b0, span_base[i]};
      b = a + span_len[i];
      if (a <= hi && b >= lo) begin
        hits++;
        if (a < u_lo) u_lo = a;
        if (b > u_hi) u_hi = b;
      end
    end
    if (hits == 0 && span_cnt >= SPANS) return STAT_FULL;
    for (int i = 0; i < span_cnt; i++) begin
      a = {1'b0, span_base[i]};
      b = a + span_len[i];
      if (!(a <= hi && b >= lo)) begin
        // The merged interval goes in front of the first interval past its end.
        if (!placed && a > u_hi) begin
          new_base[n] = u_lo;
          new_len[n] = u_hi - u_lo;
          n++;
          placed = 1'b1;
        end
        if (n < SPANS) begin
          new_base[n] = a;
          new_len[n] = b - a;
          n++;
        end
      end
    end
    if (!placed && n < SPANS) begin
      new_base[n] = u_lo;
      new_len[n] = u_hi - u_lo;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      span_base[i] = new_base[i][SW-1:0];
      span_len[i] = new_len[i];
    end
    span_cnt = n;
    return STAT_OK;
  endfunction

  function automatic coverage_t track_fragment(frag_t f);
    coverage_t res;
    logic [SW:0] stop;
    res.status = STAT_OK;
    if (f.restart) begin
      span_cnt = 0;
      chunk_done = 1'b0;
    end
    stop = {1'b0, f.offset} + {1'b0, f.length};
    if (stop > {1'b0, chunk_size}) res.status = STAT_RANGE;
    else if (f.length != '0) res.status = merge_span({1'b0, f.offset}, stop);
    // The completion check runs on rejected fragments too.
    if (span_cnt > 0 && span_base[0] == '0 && span_len[0] == {1'b0, chunk_size} &&
        chunk_size != '0) chunk_done = 1'b1;
    res.complete = chunk_done;
    res.total = OUT_TOTAL_W'(span_cnt);
    return res;
  endfunction

  function automatic int pick_idle(inout int left, inout bit quiet);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 2) == 0);
    end
    left--;
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    coverage_t want;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
    end else begin
      if (in_valid && !in_stall) begin
        want = track_fragment(frag_live);
        coverage_due = {coverage_due, want};
        frags_sent++;
        if (want.status == STAT_FULL) full_drops++;
        if (want.status == STAT_RANGE) range_drops++;
        if (want.complete) completions++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (frag_backlog.size() != 0) begin
          frag_live = frag_backlog.pop_front();
          restart <= frag_live.restart;
          frag_offset <= frag_live.offset;
          frag_length <= frag_live.length;
          in_valid <= 1'b1;
          send_gap = pick_idle(send_calm, send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    coverage_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      recv_calm = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (coverage_due.size() == 0) begin
          flag_mismatch("unexpected beat, interval_total", interval_total, 0);
        end else begin
          want = coverage_due.pop_front();
          if (complete !== want.complete) flag_mismatch("complete", complete, want.complete);
          if (status !== want.status) flag_mismatch("status", status, want.status);
          if (interval_total !== want.total)
            flag_mismatch("interval_total", interval_total, want.total);
        end
      end
      if (park_left != 0) begin
        recv_wait = park_left;
        park_left = 0;
      end else if (out_valid && !out_stall) begin
        recv_wait = pick_idle(recv_calm, recv_quiet);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d results pending",
                 quiet_cycles, coverage_due.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_frag(input logic r, input logic [SW-1:0] off, input logic [SW-1:0] len);
    frag_t f;
    f.restart = r;
    f.offset = off;
    f.length = len;
    frag_backlog = {frag_backlog, f};
    frags_queued++;
  endtask

  // One reassembly of the whole chunk: pieces in shuffled or staggered order, some overlapping,
  // sometimes one missing or one repeated. Staggered order leaves gaps that fill the list.
  task automatic queue_reassembly(input int unsigned size);
    longint unsigned lo, hi, w, ext;
    longint unsigned piece_lo[$];
    longint unsigned piece_hi[$];
    int order[$];
    int k, j, tmp;
    k = $urandom_range(1, 36);
    if (k > size) k = int'(size);
    for (int i = 0; i < k; i++) begin
      lo = longint'(i) * size / k;
      hi = (longint'(i) + 1) * size / k;
      w = hi - lo;
      if ($urandom_range(0, 3) == 0) begin
        ext = 64'($urandom_range(0, int'(w / 2)));
        lo = (lo > ext) ? lo - ext : 0;
        hi = (hi + ext < size) ? hi + ext : 64'(size);
      end
      piece_lo = {piece_lo, lo};
      piece_hi = {piece_hi, hi};
    end
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < k; i += 2) order = {order, i};
      for (int i = 1; i < k; i += 2) order = {order, i};
    end else begin
      for (int i = 0; i < k; i++) order = {order, i};
      for (int i = k - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    if (k > 1 && $urandom_range(0, 4) == 0) order.delete($urandom_range(0, k - 1));
    if ($urandom_range(0, 3) == 0) order = {order, order[$urandom_range(0, order.size() - 1)]};
    for (int i = 0; i < order.size(); i++)
      queue_frag(i == 0, SW'(piece_lo[order[i]]),
                 SW'(piece_hi[order[i]] - piece_lo[order[i]]));
  endtask

  task automatic fill_phase(input int unsigned size);
    int start_n;
    int unsigned off;
    start_n = frags_queued;
    while (frags_queued - start_n < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        7: queue_frag($urandom_range(0, 1) == 1, SW'($urandom), SW'($urandom));
        8: begin
          off = $urandom_range(0, size);
          queue_frag($urandom_range(0, 15) == 0, SW'(off), SW'($urandom_range(0, size - off)));
        end
        9: begin
          case ($urandom_range(0, 2))
            0: queue_frag(1'b0, SW'(size), '0);
            1: queue_frag(1'b0, '0, SW'(size + 1));
            default: queue_frag(1'b0, SW'($urandom_range(0, size)), '0);
          endcase
        end
        default: queue_reassembly(size);
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frag_backlog.size() != 0 || in_valid || coverage_due.size() != 0);
  endtask

  task automatic write_chunk_size(input logic [SW-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    chunk_size = v;
    sizes_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned size;
    chunk_size = SW'(CHUNK_RESET);
    span_cnt = 0;
    chunk_done = 1'b0;
    sizes_used = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Edge cases at the reset chunk size of 1024.
    queue_frag(1'b0, '0, '0);
    queue_frag(1'b0, SIZE_MAX, SIZE_MAX);
    queue_frag(1'b0, SW'(1024), '0);
    queue_frag(1'b0, SW'(1023), SW'(2));
    for (int i = 0; i < SPANS; i++) queue_frag(1'b0, SW'(64 * i), SW'(8));
    queue_frag(1'b0, SW'(1000), SW'(4));
    queue_frag(1'b0, SW'(8), SW'(56));
    queue_frag(1'b0, '0, SW'(1024));
    queue_frag(1'b1, SW'(512), SW'(512));
    queue_frag(1'b0, '0, SW'(512));

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: size = 1;
        1: size = 32'(SIZE_MAX);
        2: size = CHUNK_RESET;
        3: size = $urandom_range(2, 64);
        4: size = SPANS;
        5: size = $urandom_range(65, 5000);
        6: size = $urandom_range(1, 32'(SIZE_MAX));
        default: size = $urandom_range(1000, 100000);
      endcase
      wait_drained();
      write_chunk_size(SW'(size));
      fill_phase(size);
      if (p == 1) begin
        // Park the receiver while fragments keep coming so the input backs up.
        do @(negedge clk);
        while (frag_backlog.size() > PHASE_ITEMS / 2);
        park_left = PARK_CYCLES;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d fragments across %0d chunk sizes up to %0d bytes.",
             frags_sent, sizes_used, SIZE_MAX);
    $display("Results: %0d complete, %0d past the chunk end, %0d with the list full.",
             completions, range_drops, full_drops);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
